// ===== rtl/core/xxtea_pkg.sv =====
// Shared types, constants and the control store for the XXTEA block cipher.
// No dependencies; compiled first.
`default_nettype none

package xxtea_pkg;

   // cipher constants
   localparam logic [31:0] DELTA     = 32'h9E3779B9;
   localparam logic [31:0] KEY_RESET = 32'hDEADBEEF;

   // field and port widths
   localparam int WORD_W      = 32;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int COUNT_MAX_W = 7;   // holds a word count up to 127
   localparam int ROUNDS_W    = 6;   // at most 6 + 52/2 = 32 rounds

   // register map of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_0 = 4'd0,
      CSR_KEY_1 = 4'd1,
      CSR_KEY_2 = 4'd2,
      CSR_KEY_3 = 4'd3
   } csr_index_type;

   // control store addresses
   typedef enum logic [3:0] {
      ST_IDLE      = 4'd0,
      ST_DISPATCH  = 4'd1,
      ST_INIT      = 4'd2,
      ST_LOAD      = 4'd3,
      ST_ROUND     = 4'd4,
      ST_READ      = 4'd5,
      ST_MIX       = 4'd6,
      ST_UPDATE    = 4'd7,
      ST_END_ROUND = 4'd8,
      ST_EMIT_RD   = 4'd9,
      ST_EMIT_WAIT = 4'd10,
      ST_EMIT_PUSH = 4'd11,
      ST_DONE      = 4'd12,
      ST_ERR_WAIT  = 4'd13,
      ST_ERR_PUSH  = 4'd14,
      ST_SPARE     = 4'd15
   } step_type;

   // jump conditions
   typedef enum logic [2:0] {
      C_NEVER       = 3'd0,
      C_ALWAYS      = 3'd1,
      C_LAST_BEAT   = 3'd2,
      C_BAD_BLOCK   = 3'd3,
      C_PASS_MORE   = 3'd4,
      C_ROUNDS_MORE = 3'd5,
      C_OUT_FREE    = 3'd6,
      C_WORDS_MORE  = 3'd7
   } cond_type;

   // one control word
   typedef struct packed {
      logic     in_ready;     // take input beats
      logic     addr_carry;   // read port 0 fetches the first carry word
      logic     ld_rounds;    // load round count from block length
      logic     ld_carry;     // carry word and start sum
      logic     round_start;  // reset index, bump sum when encrypting
      logic     mix;          // register the two mix terms
      logic     update;       // write back one word, step the index
      logic     round_end;    // count a round down, clear the index
      logic     out_word;     // push a data word to the output register
      logic     out_err;      // push an error beat to the output register
      logic     clear_block;  // drop block length, overflow and direction
      cond_type cond;
      logic     hold;         // stay on this step when the jump is not taken
      step_type target;
   } uop_type;

   // control program: jump to target when cond holds, else hold or fall through
   function automatic uop_type ucode(step_type s);
      uop_type u;
      u        = '0;
      u.cond   = C_NEVER;
      u.target = ST_IDLE;
      case (s)
         ST_IDLE: begin
            u.in_ready = 1'b1;
            u.cond     = C_LAST_BEAT;
            u.hold     = 1'b1;
            u.target   = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            u.cond   = C_BAD_BLOCK;
            u.target = ST_ERR_WAIT;
         end
         ST_INIT: begin
            u.addr_carry = 1'b1;
            u.ld_rounds  = 1'b1;
         end
         ST_LOAD: begin
            u.ld_carry = 1'b1;
         end
         ST_ROUND: begin
            u.round_start = 1'b1;
         end
         ST_READ: begin
            // read addresses follow the index; data lands next cycle
         end
         ST_MIX: begin
            u.mix = 1'b1;
         end
         ST_UPDATE: begin
            u.update = 1'b1;
            u.cond   = C_PASS_MORE;
            u.target = ST_READ;
         end
         ST_END_ROUND: begin
            u.round_end = 1'b1;
            u.cond      = C_ROUNDS_MORE;
            u.target    = ST_ROUND;
         end
         ST_EMIT_RD: begin
            // fetch the word at the index
         end
         ST_EMIT_WAIT: begin
            u.cond   = C_OUT_FREE;
            u.hold   = 1'b1;
            u.target = ST_EMIT_PUSH;
         end
         ST_EMIT_PUSH: begin
            u.out_word = 1'b1;
            u.cond     = C_WORDS_MORE;
            u.target   = ST_EMIT_RD;
         end
         ST_DONE: begin
            u.clear_block = 1'b1;
            u.cond        = C_ALWAYS;
            u.target      = ST_IDLE;
         end
         ST_ERR_WAIT: begin
            u.cond   = C_OUT_FREE;
            u.hold   = 1'b1;
            u.target = ST_ERR_PUSH;
         end
         ST_ERR_PUSH: begin
            u.out_err = 1'b1;
            u.cond    = C_ALWAYS;
            u.target  = ST_DONE;
         end
         default: begin
            u.cond   = C_ALWAYS;
            u.target = ST_IDLE;
         end
      endcase
      return u;
   endfunction

   // round count 6 + 52/n for n >= 2
   function automatic logic [ROUNDS_W-1:0] rounds_for(logic [COUNT_MAX_W-1:0] n);
      logic [ROUNDS_W-1:0] r;
      if (n <= 7'd2)       r = 6'd32;
      else if (n == 7'd3)  r = 6'd23;
      else if (n == 7'd4)  r = 6'd19;
      else if (n == 7'd5)  r = 6'd16;
      else if (n == 7'd6)  r = 6'd14;
      else if (n == 7'd7)  r = 6'd13;
      else if (n == 7'd8)  r = 6'd12;
      else if (n <= 7'd10) r = 6'd11;
      else if (n <= 7'd13) r = 6'd10;
      else if (n <= 7'd17) r = 6'd9;
      else if (n <= 7'd26) r = 6'd8;
      else if (n <= 7'd52) r = 6'd7;
      else                 r = 6'd6;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/xxtea_if.sv =====
// Valid/ready channel interfaces for the XXTEA block cipher.
// Depends on xxtea_pkg for the word width.
`default_nettype none

interface xxtea_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [xxtea_pkg::WORD_W-1:0] word_in;
   logic                         last_in;

   modport source (output valid, output action, output word_in, output last_in,
                   input ready);
   modport sink   (input valid, input action, input word_in, input last_in,
                   output ready);
endinterface

interface xxtea_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [xxtea_pkg::WORD_W-1:0] word_out;
   logic                         last_out;
   logic                         error;

   modport source (output valid, output word_out, output last_out, output error,
                   input ready);
   modport sink   (input valid, input word_out, input last_out, input error,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/xxtea_block_cipher_top.sv =====
// XXTEA block cipher: block store, key registers and a microcoded sequencer.
// Depends on xxtea_pkg and the channel interfaces in xxtea_if.sv.
//
//   channel   direction  beat carries                  handshake
//   req_chan  in         action, word_in, last_in      valid/ready
//   rsp_chan  out        word_out, last_out, error     valid/ready
//   csr_*     in         key word index and data       write enable only
//
// Words of a block are taken one per cycle while the sequencer sits idle.
// A block of n words then runs R = 6 + 52/n rounds, each a pass of the three-step
// word update (read, mix, write) of the one mixing unit over every word; each result
// beat is then read, waits for a free output register and is pushed.
// Synchronous active-high reset; the store itself is not cleared.
// A stalled result holds in the output register; the sequencer waits on it.
`default_nettype none

module xxtea_block_cipher_top #(
   parameter int MAX_WORDS = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   xxtea_req_if.sink                            req_chan,
   xxtea_rsp_if.source                          rsp_chan,
   input  wire                                  csr_wr_en,
   input  wire  [xxtea_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [xxtea_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import xxtea_pkg::*;

   localparam int CW = $clog2(MAX_WORDS + 1);
   localparam int IW = $clog2(MAX_WORDS);
   localparam int KEY_WORDS_N = 4;

   // sequencer
   step_type upc_ff, upc_in;
   uop_type  uop;
   logic     cond_hit;

   // block bookkeeping
   logic [CW-1:0] cnt_ff;
   logic          ovf_ff;
   logic          dir_ff;

   // datapath
   logic [WORD_W-1:0]   key_ff [KEY_WORDS_N];
   logic [WORD_W-1:0]   store_mem [MAX_WORDS];
   logic [WORD_W-1:0]   rd0_ff, rd1_ff;
   logic [WORD_W-1:0]   carry_ff, sum_ff, a_ff, b_ff;
   logic [ROUNDS_W-1:0] rounds_ff;
   logic [IW-1:0]       p_ff;

   // output register
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_word_ff;
   logic              rsp_last_ff;
   logic              rsp_err_ff;

   logic              req_beat;
   logic              store_room;
   logic [IW-1:0]     last_idx;
   logic [IW-1:0]     addr0, addr1;
   logic              mem_we;
   logic [IW-1:0]     mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [WORD_W-1:0] mix_y, mix_z, a_in, b_in, f_val, new_word;
   logic [1:0]        key_idx;

   assign req_beat   = req_chan.valid & req_chan.ready;
   assign store_room = cnt_ff < CW'(MAX_WORDS);
   assign last_idx   = IW'(cnt_ff - CW'(1));

   // control word for the current step
   always_comb begin
      uop = ucode(upc_ff);
   end

   // jump condition and next step
   always_comb begin
      case (uop.cond)
         C_NEVER:       cond_hit = 1'b0;
         C_ALWAYS:      cond_hit = 1'b1;
         C_LAST_BEAT:   cond_hit = req_beat & req_chan.last_in;
         C_BAD_BLOCK:   cond_hit = ovf_ff | (cnt_ff < CW'(2));
         C_PASS_MORE:   cond_hit = dir_ff ? (p_ff != '0) : (p_ff != last_idx);
         C_ROUNDS_MORE: cond_hit = rounds_ff != ROUNDS_W'(1);
         C_OUT_FREE:    cond_hit = ~rsp_valid_ff | rsp_chan.ready;
         C_WORDS_MORE:  cond_hit = p_ff != last_idx;
         default:       cond_hit = 1'b0;
      endcase
      if (cond_hit) begin
         upc_in = uop.target;
      end else if (uop.hold) begin
         upc_in = upc_ff;
      end else begin
         upc_in = step_type'(upc_ff + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= ST_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   // memory addressing: port 0 is the word at the index or the first carry,
   // port 1 the neighbor that feeds the mix
   always_comb begin
      if (uop.addr_carry) begin
         addr0 = dir_ff ? '0 : last_idx;
      end else begin
         addr0 = p_ff;
      end
      if (dir_ff) begin
         addr1 = (p_ff == '0) ? last_idx : p_ff - IW'(1);
      end else begin
         addr1 = (p_ff == last_idx) ? '0 : p_ff + IW'(1);
      end
   end

   // mix terms
   always_comb begin
      mix_y    = dir_ff ? carry_ff : rd1_ff;
      mix_z    = dir_ff ? rd1_ff : carry_ff;
      a_in     = ((mix_z >> 5) ^ (mix_y << 2)) + ((mix_y >> 3) ^ (mix_z << 4));
      key_idx  = 2'(p_ff) ^ sum_ff[3:2];
      b_in     = (sum_ff ^ mix_y) + (key_ff[key_idx] ^ mix_z);
      f_val    = a_ff ^ b_ff;
      new_word = dir_ff ? rd0_ff - f_val : rd0_ff + f_val;
   end

   // store write port: input beats while idle, updated words while running
   always_comb begin
      mem_we    = uop.update | (req_beat & store_room);
      mem_waddr = uop.update ? p_ff : IW'(cnt_ff);
      mem_wdata = uop.update ? new_word : req_chan.word_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rd0_ff <= store_mem[addr0];
      rd1_ff <= store_mem[addr1];
   end

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS_N; i++) begin
            key_ff[i] <= KEY_RESET;
         end
      end else if (csr_wr_en && csr_index <= CSR_KEY_3) begin
         key_ff[csr_index[1:0]] <= csr_wr_data;
      end
   end

   // block length, overflow flag and direction
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         dir_ff <= 1'b0;
      end else if (uop.clear_block) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         dir_ff <= 1'b0;
      end else if (req_beat) begin
         if (cnt_ff == '0 && !ovf_ff) begin
            dir_ff <= req_chan.action;
         end
         if (store_room) begin
            cnt_ff <= cnt_ff + CW'(1);
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   // round state and mixing registers
   always_ff @(posedge clock) begin
      if (uop.ld_rounds) begin
         rounds_ff <= rounds_for(COUNT_MAX_W'(cnt_ff));
      end else if (uop.round_end) begin
         rounds_ff <= rounds_ff - ROUNDS_W'(1);
      end

      if (uop.ld_carry) begin
         sum_ff <= dir_ff ? 32'(rounds_ff * DELTA) : '0;
      end else if (uop.round_start && !dir_ff) begin
         sum_ff <= sum_ff + DELTA;
      end else if (uop.round_end && dir_ff) begin
         sum_ff <= sum_ff - DELTA;
      end

      if (uop.ld_carry) begin
         carry_ff <= rd0_ff;
      end else if (uop.update) begin
         carry_ff <= new_word;
      end

      if (uop.round_start) begin
         p_ff <= dir_ff ? last_idx : '0;
      end else if (uop.update) begin
         p_ff <= dir_ff ? p_ff - IW'(1) : p_ff + IW'(1);
      end else if (uop.round_end) begin
         p_ff <= '0;
      end else if (uop.out_word) begin
         p_ff <= p_ff + IW'(1);
      end

      if (uop.mix) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (uop.out_word || uop.out_err) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (uop.out_word) begin
         rsp_word_ff <= rd0_ff;
         rsp_last_ff <= p_ff == last_idx;
         rsp_err_ff  <= 1'b0;
      end else if (uop.out_err) begin
         rsp_word_ff <= '0;
         rsp_last_ff <= 1'b1;
         rsp_err_ff  <= 1'b1;
      end
   end

   assign req_chan.ready    = uop.in_ready;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.word_out = rsp_word_ff;
   assign rsp_chan.last_out = rsp_last_ff;
   assign rsp_chan.error    = rsp_err_ff;

endmodule

`default_nettype wire

// ===== rtl/core/xxtea_checker.sv =====
// Port-level assertions for the XXTEA block cipher, bound to the top level.
// Depends on xxtea_pkg and xxtea_block_cipher_top.
`default_nettype none

module xxtea_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         req_valid,
   input wire                         req_ready,
   input wire                         req_last,
   input wire                         rsp_valid,
   input wire                         rsp_ready,
   input wire [xxtea_pkg::WORD_W-1:0] rsp_word,
   input wire                         rsp_last,
   input wire                         rsp_error
);
   import xxtea_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // an error beat is a lone, zero, final beat
   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && rsp_word == '0)
      else $error("error beat not final or not zero");

   // closing a block stops intake while it is worked on
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("input taken right after a block end");

   // while taking input, only a block's final result may still wait
   a_idle_pending: assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_last)
      else $error("input taken while a block is still being emitted");

endmodule

bind xxtea_block_cipher_top xxtea_checker u_xxtea_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_last  (req_chan.last_in),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_word  (rsp_chan.word_out),
   .rsp_last  (rsp_chan.last_out),
   .rsp_error (rsp_chan.error)
);

`default_nettype wire

// ===== tb/xxtea_cipher_checker.sv =====
`timescale 1ns / 100ps
// Checker for the XXTEA block cipher: predicts the result beats of each block.
// It works from the request beats and key writes it sees, then compares them with the response channel.
// Depends on xxtea_pkg and the channel interfaces in xxtea_if.sv.

module xxtea_cipher_checker #(
   parameter int MAX_WORDS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   xxtea_req_if                                req_mon,
   xxtea_rsp_if                                rsp_mon,
   input  logic                                csr_wr_en,
   input  logic [xxtea_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [xxtea_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   output int                                  mismatch_count,
   output int                                  beats_pending
);
   import xxtea_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
      logic              error;
   } cipher_beat_type;

   // expected result beats, oldest first
   cipher_beat_type   cipher_beats_due[$];

   // shadow of the block's state
   logic [WORD_W-1:0] key_reg[4];
   logic [WORD_W-1:0] block_words[MAX_WORDS];
   int                words_held;
   logic              decrypting;
   logic              overflowed;

   // one XXTEA mixing term
   function automatic logic [WORD_W-1:0] mix_term(input logic [WORD_W-1:0] y,
                                                  input logic [WORD_W-1:0] z,
                                                  input logic [WORD_W-1:0] sum,
                                                  input int p,
                                                  input logic [1:0] e);
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
      b = (sum ^ y) + (key_reg[p[1:0] ^ e] ^ z);
      return a ^ b;
   endfunction

   // forward rounds over the held words, in place
   task automatic encipher_block();
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
      logic [WORD_W-1:0] sum;
      logic [1:0]        e;
      int                n;
      n   = words_held;
      z   = block_words[n-1];
      sum = '0;
      repeat (6 + 52 / n) begin
         sum = sum + DELTA;
         e   = sum[3:2];
         for (int p = 0; p < n - 1; p++) begin
            y              = block_words[p+1];
            block_words[p] = block_words[p] + mix_term(y, z, sum, p, e);
            z              = block_words[p];
         end
         y                = block_words[0];
         block_words[n-1] = block_words[n-1] + mix_term(y, z, sum, n - 1, e);
         z                = block_words[n-1];
      end
   endtask

   // inverse rounds: sum starts at rounds * delta and walks back to zero
   task automatic decipher_block();
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
      logic [WORD_W-1:0] sum;
      logic [1:0]        e;
      int                n;
      n   = words_held;
      y   = block_words[0];
      sum = '0;
      repeat (6 + 52 / n) sum = sum + DELTA;
      repeat (6 + 52 / n) begin
         e = sum[3:2];
         for (int p = n - 1; p > 0; p--) begin
            z              = block_words[p-1];
            block_words[p] = block_words[p] - mix_term(y, z, sum, p, e);
            y              = block_words[p];
         end
         z              = block_words[n-1];
         block_words[0] = block_words[0] - mix_term(y, z, sum, 0, e);
         y              = block_words[0];
         sum            = sum - DELTA;
      end
   endtask

   // absorb one request beat; a last beat queues the block's results
   task automatic absorb_word(input logic act, input logic [WORD_W-1:0] w, input logic lst);
      cipher_beat_type beat;
      if (words_held == 0 && !overflowed) decrypting = act;
      if (words_held < MAX_WORDS) begin
         block_words[words_held] = w;
         words_held++;
      end else begin
         overflowed = 1'b1;
      end
      if (lst) begin
         if (overflowed || words_held < 2) begin
            // short or overlong block: one error beat
            beat.word  = '0;
            beat.last  = 1'b1;
            beat.error = 1'b1;
            cipher_beats_due.push_back(beat);
         end else begin
            if (decrypting) decipher_block();
            else encipher_block();
            for (int k = 0; k < words_held; k++) begin
               beat.word  = block_words[k];
               beat.last  = (k == words_held - 1);
               beat.error = 1'b0;
               cipher_beats_due.push_back(beat);
            end
         end
         words_held = 0;
         overflowed = 1'b0;
         decrypting = 1'b0;
      end
   endtask

   task automatic compare_field(input string field, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // watch both channels and the key writes at each edge
   always @(posedge clock) begin : watch_channels
      cipher_beat_type want;
      if (reset) begin
         for (int i = 0; i < 4; i++) key_reg[i] = KEY_RESET;
         words_held     = 0;
         decrypting     = 1'b0;
         overflowed     = 1'b0;
         mismatch_count = 0;
         cipher_beats_due.delete();
      end else begin
         if (csr_wr_en && csr_index <= CSR_KEY_3) key_reg[csr_index[1:0]] = csr_wr_data;
         if (req_mon.valid && req_mon.ready)
            absorb_word(req_mon.action, req_mon.word_in, req_mon.last_in);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (cipher_beats_due.size() == 0) begin
               $display("%0t: unexpected result beat, expected none actual %h last %b error %b",
                        $time, rsp_mon.word_out, rsp_mon.last_out, rsp_mon.error);
               mismatch_count++;
            end else begin
               want = cipher_beats_due.pop_front();
               compare_field("word_out", want.word, rsp_mon.word_out);
               compare_field("last_out", WORD_W'(want.last), WORD_W'(rsp_mon.last_out));
               compare_field("error", WORD_W'(want.error), WORD_W'(rsp_mon.error));
            end
         end
      end
      beats_pending = cipher_beats_due.size();
   end

endmodule

// ===== tb/xxtea_block_cipher_top_test.sv =====
`timescale 1ns / 100ps
// Top of the XXTEA block cipher test: clock, reset, key writes, request stimulus, and
// response back-pressure. Depends on xxtea_pkg, xxtea_if.sv, the RTL top and xxtea_cipher_checker.

module xxtea_block_cipher_top_test;
   import xxtea_pkg::*;

   localparam int   BLOCK_MAX        = 16;
   localparam int   CLOCK_PERIOD     = 20;
   localparam int   RESET_CYCLES     = 9;
   localparam int   SETTLE_CYCLES    = 32;
   localparam int   LONG_HOLD_CYCLES = 600;
   localparam int   STALL_LIMIT      = 5000;
   localparam logic ACT_ENCRYPT      = 1'b0;
   localparam logic ACT_DECRYPT      = 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 4'd9;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;
   int                     mismatch_count;
   int                     beats_pending;
   int                     sender_idle_pct;
   int                     receiver_stall_pct;
   int                     hold_requests;
   int                     idle_cycles;

   xxtea_req_if req_chan ();
   xxtea_rsp_if rsp_chan ();

   xxtea_block_cipher_top #(.MAX_WORDS(BLOCK_MAX)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   xxtea_cipher_checker #(.MAX_WORDS(BLOCK_MAX)) cipher_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .beats_pending  (beats_pending)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // response side: random stalls, plus a long hold-off on request
   initial begin : response_sink
      int hold_left;
      int holds_seen;
      hold_left  = 0;
      holds_seen = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left  = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // watchdog: too long without any beat on either channel
   initial idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return 32'h8000_0000;
         3:       return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   // mostly well-formed blocks, short ones favored; a few too short or too long
   function automatic int pick_block_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 6) return 1;
      else if (roll < 12) return BLOCK_MAX + $urandom_range(1, 4);
      else if (roll < 20) return BLOCK_MAX;
      else if (roll < 30) return $urandom_range(9, BLOCK_MAX - 1);
      else return $urandom_range(2, 8);
   endfunction

   // offer one request beat and hold it until accepted
   task automatic send_beat(input logic act, input logic [WORD_W-1:0] w, input logic lst);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.action  <= act;
      req_chan.word_in <= w;
      req_chan.last_in <= lst;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
   endtask

   task automatic send_random_blocks(input int goal);
      int   sent;
      int   n;
      logic block_act;
      logic beat_act;
      sent = 0;
      while (sent < goal) begin
         n         = pick_block_length();
         block_act = logic'($urandom_range(1));
         for (int i = 0; i < n; i++) begin
            beat_act = (i == 0) ? block_act : logic'($urandom_range(1));
            send_beat(beat_act, random_word(), i == n - 1);
         end
         sent += n;
      end
   endtask

   // stop offering, wait for every expected beat, then let the sequencer go idle
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (beats_pending == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                           input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_KEY_0;  csr_wr_data <= k0;  @(posedge clock);
      csr_index <= CSR_KEY_1;  csr_wr_data <= k1;  @(posedge clock);
      csr_index <= CSR_KEY_2;  csr_wr_data <= k2;  @(posedge clock);
      csr_index <= CSR_KEY_3;  csr_wr_data <= k3;  @(posedge clock);
      // unmapped index must leave the key alone
      csr_index <= CSR_UNMAPPED;  csr_wr_data <= $urandom;  @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_KEY_0;
      csr_wr_data      <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.action  <= ACT_ENCRYPT;
      req_chan.word_in <= '0;
      req_chan.last_in <= 1'b0;
      sender_idle_pct  = 0;
      receiver_stall_pct <= 0;
      hold_requests      <= 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed blocks under the reset key
      send_beat(ACT_ENCRYPT, 32'h0000_0000, 1'b0);
      send_beat(ACT_ENCRYPT, 32'hFFFF_FFFF, 1'b1);
      send_beat(ACT_DECRYPT, 32'hFFFF_FFFF, 1'b0);
      send_beat(ACT_DECRYPT, 32'h8000_0001, 1'b1);
      // one-word block
      send_beat(ACT_DECRYPT, 32'h1234_5678, 1'b1);
      // action on later beats is ignored
      send_beat(ACT_ENCRYPT, 32'h0123_4567, 1'b0);
      send_beat(ACT_DECRYPT, 32'h89AB_CDEF, 1'b0);
      send_beat(ACT_DECRYPT, 32'hFEDC_BA98, 1'b1);
      // one word too many
      for (int i = 0; i <= BLOCK_MAX; i++)
         send_beat((i == 0) ? ACT_DECRYPT : ACT_ENCRYPT, random_word(), i == BLOCK_MAX);
      drain_results();

      // all-zero key, no idling
      load_key('0, '0, '0, '0);
      send_random_blocks(100);
      drain_results();

      // all-ones key, sender idles
      load_key('1, '1, '1, '1);
      sender_idle_pct = 53;
      send_random_blocks(100);
      drain_results();

      // random key, receiver stalls; starts with a long hold-off to back up the input
      load_key($urandom, $urandom, $urandom, $urandom);
      sender_idle_pct = 0;
      receiver_stall_pct <= 53;
      hold_requests      <= hold_requests + 1;
      send_random_blocks(100);
      drain_results();

      // random key, light idling on both sides
      load_key($urandom, $urandom, $urandom, $urandom);
      sender_idle_pct = 11;
      receiver_stall_pct <= 11;
      send_random_blocks(105);
      drain_results();

      if (mismatch_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
